[rtl/p2x_pkg.sv]
package p2x_pkg;

	localparam int WIDTH_LIMIT  = 1024;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int ADDR_W       = $clog2(WIDTH_LIMIT);
	localparam int COL_W        = ADDR_W + 1;
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int HGT_W        = ROW_W + 1;
	localparam int BANKS        = 4;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_AW + 1;

	localparam logic       OP_PIXEL = 1'b0;
	localparam logic       OP_DRAIN = 1'b1;

	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

	localparam logic FMT_RGB565   = 1'b0;
	localparam logic FMT_XRGB8888 = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_tl;
		logic [31:0] pixel_tr;
		logic [31:0] pixel_bl;
		logic [31:0] pixel_br;
		logic [11:0] src_row;
		logic [9:0]  src_col;
		logic        last_of_run;
		logic        frame_done;
	} res_item_t;

	// Frame settings as the datapath uses them (width and height already saturated).
	typedef struct packed {
		logic             fmt;
		logic [COL_W-1:0] w;
		logic [HGT_W-1:0] h;
	} cfg_t;

	typedef enum logic [1:0] {
		ACT_FILL,
		ACT_SHIFT,
		ACT_DUP
	} act_kind_t;

	typedef struct packed {
		act_kind_t   kind;
		logic        emit;
		logic        last;
		logic        done;
		logic [11:0] row;
		logic [9:0]  col;
	} act_meta_t;

	typedef struct packed {
		act_meta_t       meta;
		logic [3:0][1:0] bank;
		logic            use_pix;
		logic [31:0]     pix;
	} iss_t;

	typedef struct packed {
		act_meta_t        meta;
		logic [3:0][31:0] column;
	} act_t;

	typedef enum logic [2:0] {
		FS_RUN,
		FS_PIX_DUP1,
		FS_PIX_DUP2,
		FS_DRN_COL1,
		FS_DRN_COL2
	} fe_state_t;

endpackage

[rtl/p2x_line_store.sv]
module p2x_line_store (
	input  logic                              clk,
	input  logic                              we,
	input  logic [1:0]                        wbank,
	input  logic [p2x_pkg::ADDR_W-1:0]        waddr,
	input  logic [31:0]                       wdata,
	input  logic [p2x_pkg::ADDR_W-1:0]        raddr,
	output logic [p2x_pkg::BANKS-1:0][31:0]   rdata
);

	// One line memory per bank; all banks are read at the same column.
	for (genvar g = 0; g < p2x_pkg::BANKS; g++) begin : g_bank
		logic [31:0] mem [p2x_pkg::WIDTH_LIMIT];
		logic [31:0] rd_q;

		always_ff @(posedge clk) begin
			if (we && (wbank == 2'(g))) begin
				mem[waddr] <= wdata;
			end
			rd_q <= mem[raddr];
		end

		assign rdata[g] = rd_q;
	end

endmodule

[rtl/p2x_front.sv]
module p2x_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  p2x_pkg::in_item_t             src_item,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  p2x_pkg::cfg_t                 cfg,
	input  logic                          restart,
	input  logic [p2x_pkg::Q_CNT_W-1:0]   q_count,
	output logic                          push,
	output p2x_pkg::act_t                 push_act
);

	p2x_pkg::fe_state_t st_q, st_d;

	logic [p2x_pkg::COL_W-1:0] x_q, x_d;
	logic [11:0]               y_q, y_d;
	logic                      done_q, done_d;
	logic                      half_q, half_d;
	logic [p2x_pkg::COL_W-1:0] j_q, j_d;
	logic [11:0]               pend_q, pend_d;

	logic                      s1_valid_q;
	p2x_pkg::iss_t             iss, iss_s1;

	logic                      issue;
	logic                      space;
	logic                      we;
	logic [31:0]               pix;
	logic [p2x_pkg::ADDR_W-1:0] raddr;
	logic [p2x_pkg::BANKS-1:0][31:0] rdata;

	logic [p2x_pkg::COL_W-1:0] w1;
	logic [p2x_pkg::HGT_W-1:0] h1;
	logic [1:0]                yb, hb;
	logic [11:0]               drow;
	logic [3:0][1:0]           dbank;
	logic [p2x_pkg::COL_W-1:0] j2;

	assign space = (q_count + {{(p2x_pkg::Q_CNT_W-1){1'b0}}, s1_valid_q})
		< p2x_pkg::Q_CNT_W'(p2x_pkg::Q_DEPTH);

	assign w1   = cfg.w - 1'b1;
	assign h1   = cfg.h - 1'b1;
	assign yb   = y_q[1:0];
	assign hb   = cfg.h[1:0];
	assign drow = 12'(cfg.h - p2x_pkg::HGT_W'(2)) + {11'd0, half_q};
	assign j2   = j_q + p2x_pkg::COL_W'(2);
	assign pix  = (cfg.fmt == p2x_pkg::FMT_RGB565) ? {16'd0, src_item.pixel_in[15:0]}
		: src_item.pixel_in;

	// Drain columns: the rows below the frame repeat the last line.
	always_comb begin
		if (!half_q) begin
			dbank = {hb - 2'd1, hb - 2'd1, hb - 2'd2, hb - 2'd3};
		end else begin
			dbank = {hb - 2'd1, hb - 2'd1, hb - 2'd1, hb - 2'd2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= p2x_pkg::FS_RUN;
			x_q    <= '0;
			y_q    <= '0;
			done_q <= 1'b0;
			half_q <= 1'b0;
			j_q    <= '0;
		end else if (restart) begin
			st_q   <= p2x_pkg::FS_RUN;
			x_q    <= '0;
			y_q    <= '0;
			done_q <= 1'b0;
			half_q <= 1'b0;
			j_q    <= '0;
		end else begin
			st_q   <= st_d;
			x_q    <= x_d;
			y_q    <= y_d;
			done_q <= done_d;
			half_q <= half_d;
			j_q    <= j_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

	always_comb begin
		st_d      = st_q;
		x_d       = x_q;
		y_d       = y_q;
		done_d    = done_q;
		half_d    = half_q;
		j_d       = j_q;
		pend_d    = pend_q;
		src_ready = 1'b0;
		issue     = 1'b0;
		we        = 1'b0;
		raddr     = '0;
		iss       = '0;
		iss.pix   = pix;

		case (st_q)
			p2x_pkg::FS_RUN: begin
				src_ready = space;
				if (src_valid && space) begin
					if (src_item.op == p2x_pkg::OP_PIXEL) begin
						if (!done_q) begin
							issue = 1'b1;
							we    = 1'b1;
							raddr = x_q[p2x_pkg::ADDR_W-1:0];
							iss.meta.kind = (x_q == '0) ? p2x_pkg::ACT_FILL : p2x_pkg::ACT_SHIFT;
							iss.meta.emit = (y_q >= 12'd2) && (x_q >= p2x_pkg::COL_W'(2));
							iss.meta.last = iss.meta.emit && (x_q != w1);
							iss.meta.row  = y_q - 12'd2;
							iss.meta.col  = 10'(x_q - p2x_pkg::COL_W'(2));
							iss.bank[0]   = (y_q == 12'd2) ? 2'd0 : yb - 2'd3;
							iss.bank[1]   = yb - 2'd2;
							iss.bank[2]   = yb - 2'd1;
							iss.bank[3]   = yb;
							iss.use_pix   = 1'b1;
							if (iss.meta.emit && (x_q == w1)) begin
								st_d   = p2x_pkg::FS_PIX_DUP1;
								pend_d = y_q - 12'd2;
							end
							if (x_q == w1) begin
								x_d = '0;
								if ({1'b0, y_q} == h1) begin
									y_d    = '0;
									done_d = 1'b1;
								end else begin
									y_d = y_q + 12'd1;
								end
							end else begin
								x_d = x_q + 1'b1;
							end
						end
					end else if (done_q) begin
						issue     = 1'b1;
						iss.bank  = dbank;
						iss.meta.row = drow;
						if (j_q == '0) begin
							// A drain line starts by loading its first three columns.
							iss.meta.kind = p2x_pkg::ACT_FILL;
							raddr         = '0;
							st_d          = p2x_pkg::FS_DRN_COL1;
						end else begin
							iss.meta.kind = (j2 <= w1) ? p2x_pkg::ACT_SHIFT : p2x_pkg::ACT_DUP;
							raddr         = j2[p2x_pkg::ADDR_W-1:0];
							iss.meta.emit = 1'b1;
							iss.meta.last = 1'b1;
							iss.meta.done = half_q && (j_q == w1);
							iss.meta.col  = j_q[9:0];
							if (j_q == w1) begin
								j_d = '0;
								if (half_q) begin
									half_d = 1'b0;
									done_d = 1'b0;
									x_d    = '0;
									y_d    = '0;
								end else begin
									half_d = 1'b1;
								end
							end else begin
								j_d = j_q + 1'b1;
							end
						end
					end
				end
			end
			p2x_pkg::FS_PIX_DUP1: begin
				if (space) begin
					issue         = 1'b1;
					iss.meta.kind = p2x_pkg::ACT_DUP;
					iss.meta.emit = 1'b1;
					iss.meta.row  = pend_q;
					iss.meta.col  = 10'(cfg.w - p2x_pkg::COL_W'(2));
					st_d          = p2x_pkg::FS_PIX_DUP2;
				end
			end
			p2x_pkg::FS_PIX_DUP2: begin
				if (space) begin
					issue         = 1'b1;
					iss.meta.kind = p2x_pkg::ACT_DUP;
					iss.meta.emit = 1'b1;
					iss.meta.last = 1'b1;
					iss.meta.row  = pend_q;
					iss.meta.col  = w1[9:0];
					st_d          = p2x_pkg::FS_RUN;
				end
			end
			p2x_pkg::FS_DRN_COL1: begin
				if (space) begin
					issue         = 1'b1;
					iss.bank      = dbank;
					iss.meta.kind = p2x_pkg::ACT_SHIFT;
					raddr         = p2x_pkg::ADDR_W'(1);
					st_d          = p2x_pkg::FS_DRN_COL2;
				end
			end
			p2x_pkg::FS_DRN_COL2: begin
				if (space) begin
					issue         = 1'b1;
					iss.bank      = dbank;
					iss.meta.kind = p2x_pkg::ACT_SHIFT;
					iss.meta.emit = 1'b1;
					iss.meta.last = 1'b1;
					iss.meta.row  = drow;
					iss.meta.col  = '0;
					raddr         = p2x_pkg::ADDR_W'(2);
					j_d           = p2x_pkg::COL_W'(1);
					st_d          = p2x_pkg::FS_RUN;
				end
			end
			default: begin
				st_d = p2x_pkg::FS_RUN;
			end
		endcase
	end

	p2x_line_store u_lines (
		.clk   (clk),
		.we    (we),
		.wbank (yb),
		.waddr (x_q[p2x_pkg::ADDR_W-1:0]),
		.wdata (pix),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		iss_s1 <= iss;
	end

	always_comb begin
		push_act.meta = iss_s1.meta;
		for (int r = 0; r < 4; r++) begin
			push_act.column[r] = rdata[iss_s1.bank[r]];
		end
		if (iss_s1.use_pix) begin
			push_act.column[3] = iss_s1.pix;
		end
	end

	assign push = s1_valid_q;

endmodule

[rtl/p2x_queue.sv]
module p2x_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  p2x_pkg::act_t                 push_act,
	input  logic                          pop,
	output logic                          valid,
	output p2x_pkg::act_t                 act,
	output logic [p2x_pkg::Q_CNT_W-1:0]   count
);

	p2x_pkg::act_t              ent_q [p2x_pkg::Q_DEPTH];
	logic [p2x_pkg::Q_AW-1:0]   wptr_q, rptr_q;
	logic [p2x_pkg::Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{(p2x_pkg::Q_CNT_W-1){1'b0}}, push}
				- {{(p2x_pkg::Q_CNT_W-1){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_act;
		end
	end

	assign valid = (cnt_q != '0);
	assign act   = ent_q[rptr_q];
	assign count = cnt_q;

endmodule

[rtl/p2x_back.sv]
module p2x_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fmt,
	input  logic                  q_valid,
	input  p2x_pkg::act_t         q_act,
	output logic                  q_pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output p2x_pkg::res_item_t    res_item
);

	logic [3:0][3:0][31:0] win_q;
	logic                  e_valid_s2;
	p2x_pkg::act_meta_t    meta_s2;
	logic                  res_valid_q;
	p2x_pkg::res_item_t    res_q;
	logic                  e_move;

	logic [31:0] pI, pE, pF, pJ, pG, pA, pB, pK, pH, pC, pD, pL, pM, pN, pO;
	logic [31:0] tr, bl, br;
	logic [2:0]  vp, vn;

	function automatic logic [31:0] avg2(input logic f, input logic [31:0] a,
		input logic [31:0] b);
		logic [31:0] s;
		if (f == p2x_pkg::FMT_RGB565) begin
			s = ((a & 32'h0000F7DE) >> 1) + ((b & 32'h0000F7DE) >> 1) + (a & b & 32'h00000821);
			s = s & 32'h0000FFFF;
		end else begin
			s = ((a & 32'hFEFEFEFE) >> 1) + ((b & 32'hFEFEFEFE) >> 1) + (a & b & 32'h01010101);
		end
		return s;
	endfunction

	function automatic logic [31:0] avg4(input logic f, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] hi, lo, s;
		if (f == p2x_pkg::FMT_RGB565) begin
			hi = ((a & 32'h0000E79C) >> 2) + ((b & 32'h0000E79C) >> 2)
				+ ((c & 32'h0000E79C) >> 2) + ((d & 32'h0000E79C) >> 2);
			lo = (a & 32'h00001863) + (b & 32'h00001863) + (c & 32'h00001863)
				+ (d & 32'h00001863);
			s  = (hi + ((lo >> 2) & 32'h00001863)) & 32'h0000FFFF;
		end else begin
			hi = ((a & 32'hFCFCFCFC) >> 2) + ((b & 32'hFCFCFCFC) >> 2)
				+ ((c & 32'hFCFCFCFC) >> 2) + ((d & 32'hFCFCFCFC) >> 2);
			lo = (a & 32'h03030303) + (b & 32'h03030303) + (c & 32'h03030303)
				+ (d & 32'h03030303);
			s  = hi + ((lo >> 2) & 32'h03030303);
		end
		return s;
	endfunction

	assign e_move = e_valid_s2 && (!res_valid_q || res_ready);
	assign q_pop  = q_valid && (!e_valid_s2 || e_move);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			case (q_act.meta.kind)
				p2x_pkg::ACT_FILL:  win_q <= {4{q_act.column}};
				p2x_pkg::ACT_SHIFT: win_q <= {q_act.column, win_q[3], win_q[2], win_q[1]};
				p2x_pkg::ACT_DUP:   win_q <= {win_q[3], win_q[3], win_q[2], win_q[1]};
				default:            win_q <= win_q;
			endcase
			meta_s2 <= q_act.meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_s2  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				e_valid_s2 <= q_act.meta.emit;
			end else if (e_move) begin
				e_valid_s2 <= 1'b0;
			end
			if (e_move) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Window columns run oldest first; within a column, row 0 lies above the centre.
	assign pI = win_q[0][0]; assign pE = win_q[1][0]; assign pF = win_q[2][0];
	assign pJ = win_q[3][0];
	assign pG = win_q[0][1]; assign pA = win_q[1][1]; assign pB = win_q[2][1];
	assign pK = win_q[3][1];
	assign pH = win_q[0][2]; assign pC = win_q[1][2]; assign pD = win_q[2][2];
	assign pL = win_q[3][2];
	assign pM = win_q[0][3]; assign pN = win_q[1][3]; assign pO = win_q[2][3];

	always_comb begin
		vp = 3'(pG != pA || pE != pA) + 3'(pK != pA || pF != pA)
			+ 3'(pH != pA || pN != pA) + 3'(pL != pA || pO != pA);
		vn = 3'(pG != pB || pE != pB) + 3'(pK != pB || pF != pB)
			+ 3'(pH != pB || pN != pB) + 3'(pL != pB || pO != pB);

		if (pA == pD && pB != pC) begin
			tr = ((pA == pE && pB == pL) || (pA == pC && pA == pF && pB != pE && pB == pJ))
				? pA : avg2(fmt, pA, pB);
			bl = ((pA == pG && pC == pO) || (pA == pB && pA == pH && pG != pC && pC == pM))
				? pA : avg2(fmt, pA, pC);
			br = pA;
		end else if (pB == pC && pA != pD) begin
			tr = ((pB == pF && pA == pH) || (pB == pE && pB == pD && pA != pF && pA == pI))
				? pB : avg2(fmt, pA, pB);
			bl = ((pC == pH && pA == pF) || (pC == pG && pC == pD && pA != pH && pA == pI))
				? pC : avg2(fmt, pA, pC);
			br = pB;
		end else if (pA == pD && pB == pC) begin
			if (pA == pB) begin
				tr = pA;
				bl = pA;
				br = pA;
			end else begin
				tr = avg2(fmt, pA, pB);
				bl = avg2(fmt, pA, pC);
				if (vp > vn) begin
					br = pA;
				end else if (vp < vn) begin
					br = pB;
				end else begin
					br = avg4(fmt, pA, pB, pC, pD);
				end
			end
		end else begin
			br = avg4(fmt, pA, pB, pC, pD);
			if (pA == pC && pA == pF && pB != pE && pB == pJ) begin
				tr = pA;
			end else if (pB == pE && pB == pD && pA != pF && pA == pI) begin
				tr = pB;
			end else begin
				tr = avg2(fmt, pA, pB);
			end
			if (pA == pB && pA == pH && pG != pC && pC == pM) begin
				bl = pA;
			end else if (pC == pG && pC == pD && pA != pH && pA == pI) begin
				bl = pC;
			end else begin
				bl = avg2(fmt, pA, pC);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e_move) begin
			res_q.pixel_tl    <= pA;
			res_q.pixel_tr    <= tr;
			res_q.pixel_bl    <= bl;
			res_q.pixel_br    <= br;
			res_q.src_row     <= meta_s2.row;
			res_q.src_col     <= meta_s2.col;
			res_q.last_of_run <= meta_s2.last;
			res_q.frame_done  <= meta_s2.done;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

[rtl/pixel_art_2x_upscaler.sv]
// 2xSaI pixel-art upscaler. Source pixels enter in raster order on the src channel (op = 0),
// RGB565 in the low 16 bits or XRGB8888, and every source pixel comes back on the res channel
// as a 2x2 block with its source row and column. A block leaves as soon as the last pixel of its
// 4x4 neighbourhood has arrived, so blocks lag the input by two rows and two columns; at the
// last column of a line the two remaining blocks of that row follow, giving three results for
// that item. After the frame's last pixel, send 2 x width drain items (op = 1) to flush the final
// two rows, one block each; the last one carries frame_done and starts a new frame. Pixels sent
// after the frame is complete, and drain items sent before, are taken and dropped. Edge pixels
// are repeated for neighbours outside the frame. The block takes one item per clock while the
// action queue has room; a pixel that ends a line with blocks to give holds the front end until
// one action per block has issued, the drain item of each drain line's first column until three
// line-store reads have primed the window. The back end delivers at most one block per clock.
// The first result of an accepted pixel passes the issue, queue, window and result registers.
// The user makes configuration writes only while the block is idle; it does not enforce this.
// They restart the frame; width and height are clamped to 4..1024 and 4..4096.
module pixel_art_2x_upscaler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  p2x_pkg::in_item_t    src_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output p2x_pkg::res_item_t   res_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [12:0]          cfg_data
);

	logic                        fmt_q;
	logic [10:0]                 fw_q;
	logic [12:0]                 fh_q;
	logic                        restart;
	p2x_pkg::cfg_t               cfg;

	logic                        push;
	p2x_pkg::act_t               push_act;
	logic                        q_pop;
	logic                        q_valid;
	p2x_pkg::act_t               q_act;
	logic [p2x_pkg::Q_CNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && ((cfg_index == p2x_pkg::CFG_PIXEL_FORMAT)
		|| (cfg_index == p2x_pkg::CFG_FRAME_WIDTH) || (cfg_index == p2x_pkg::CFG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= p2x_pkg::FMT_XRGB8888;
			fw_q  <= 11'd640;
			fh_q  <= 13'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				p2x_pkg::CFG_PIXEL_FORMAT: fmt_q <= cfg_data[0];
				p2x_pkg::CFG_FRAME_WIDTH:  fw_q  <= cfg_data[10:0];
				p2x_pkg::CFG_FRAME_HEIGHT: fh_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Saturated frame size as the datapath uses it.
	always_comb begin
		cfg.fmt = fmt_q;
		if (fw_q < 11'd4) begin
			cfg.w = p2x_pkg::COL_W'(4);
		end else if ({1'b0, fw_q} > 12'(p2x_pkg::WIDTH_LIMIT)) begin
			cfg.w = p2x_pkg::COL_W'(p2x_pkg::WIDTH_LIMIT);
		end else begin
			cfg.w = p2x_pkg::COL_W'(fw_q);
		end
		if (fh_q < 13'd4) begin
			cfg.h = p2x_pkg::HGT_W'(4);
		end else if ({1'b0, fh_q} > 14'(p2x_pkg::HEIGHT_LIMIT)) begin
			cfg.h = p2x_pkg::HGT_W'(p2x_pkg::HEIGHT_LIMIT);
		end else begin
			cfg.h = p2x_pkg::HGT_W'(fh_q);
		end
	end

	// Front end: tracks the raster position, writes the line store and turns each item into
	// window actions (load a column, repeat the last column), each flagged if a block is due.
	p2x_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_item  (src_item),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.cfg       (cfg),
		.restart   (restart),
		.q_count   (q_count),
		.push      (push),
		.push_act  (push_act)
	);

	// Short queue of window actions; the front end reserves a slot before each line-store read.
	p2x_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_act (push_act),
		.pop      (q_pop),
		.valid    (q_valid),
		.act      (q_act),
		.count    (q_count)
	);

	// Back end: slides the 4x4 window, applies the 2xSaI rules and holds the result register.
	p2x_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt_q),
		.q_valid   (q_valid),
		.q_act     (q_act),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
